FILE: rtl/broadcast_range_estimator_assert.svh
// assertion macros used by the range estimator top level
`ifndef BROADCAST_RANGE_ESTIMATOR_ASSERT_SVH
`define BROADCAST_RANGE_ESTIMATOR_ASSERT_SVH

// property that must hold in the same cycle as its trigger
`define BRE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// property that must hold in the cycle after its trigger
`define BRE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/bre_pkg.sv
// shared types, constants and codes of the broadcast range estimator
`timescale 1ns / 1ps
`default_nettype none

package bre_pkg;

  // default window depth
  localparam int WINDOW_DEPTH_DEF = 8;

  // field widths
  localparam int DW        = 16;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 16;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 80;

  // 100 m in Q12.4, used for empty range entries and for a zero range
  localparam logic [DW-1:0] DEFAULT_RANGE = 16'd1600;

  // configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_CW_MIN = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_CW_MAX = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_EST_EN = 2'd2;

  // configuration reset values
  localparam logic [DW-1:0] CW_MIN_RST = 16'd32;
  localparam logic [DW-1:0] CW_MAX_RST = 16'd1024;

  // one quotient bit per divider step
  localparam int DIV_STEPS = 32;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRITE,
    ST_SCAN,
    ST_DRAIN,
    ST_DIFF,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load_in;
    logic wr_win;
    logic scan_clr;
    logic scan_rd;
    logic diff_ld;
    logic mul_ld;
    logic div_step;
    logic out_ld;
  } cmd_t;

endpackage

`default_nettype wire

FILE: rtl/bre_ram.sv
// generic single-port-write ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module bre_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/bre_ctrl.sv
// sequencing state machine of the broadcast range estimator
`timescale 1ns / 1ps
`default_nettype none

module bre_ctrl #(
  parameter int WINDOW_DEPTH = bre_pkg::WINDOW_DEPTH_DEF,
  localparam int AW = $clog2(2 * WINDOW_DEPTH),
  localparam int CW = (AW > 5) ? AW : 5
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  output bre_pkg::cmd_t      cmd,
  output logic [AW-1:0]      scan_addr
);

  bre_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            out_vld_r;
  logic            out_free;

  assign out_free  = !out_vld_r || out_ready;
  assign in_ready  = (state_r == bre_pkg::ST_IDLE);
  assign out_valid = out_vld_r;
  assign scan_addr = cnt_r[AW-1:0];

  // next state and step counter
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      bre_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = bre_pkg::ST_WRITE;
        end
      end
      bre_pkg::ST_WRITE: begin
        state_nxt = bre_pkg::ST_SCAN;
        cnt_nxt   = '0;
      end
      bre_pkg::ST_SCAN: begin
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r == CW'(2 * WINDOW_DEPTH - 1)) begin
          state_nxt = bre_pkg::ST_DRAIN;
        end
      end
      bre_pkg::ST_DRAIN: begin
        state_nxt = bre_pkg::ST_DIFF;
      end
      bre_pkg::ST_DIFF: begin
        state_nxt = bre_pkg::ST_MUL;
      end
      bre_pkg::ST_MUL: begin
        state_nxt = bre_pkg::ST_DIV;
        cnt_nxt   = '0;
      end
      bre_pkg::ST_DIV: begin
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r == CW'(bre_pkg::DIV_STEPS - 1)) begin
          state_nxt = bre_pkg::ST_DONE;
        end
      end
      bre_pkg::ST_DONE: begin
        if (out_free) begin
          state_nxt = bre_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = bre_pkg::ST_IDLE;
      end
    endcase
  end

  // datapath commands
  always_comb begin
    cmd = '0;
    case (state_r)
      bre_pkg::ST_IDLE:  cmd.load_in  = in_valid;
      bre_pkg::ST_WRITE: begin
        cmd.wr_win   = 1'b1;
        cmd.scan_clr = 1'b1;
      end
      bre_pkg::ST_SCAN:  cmd.scan_rd  = 1'b1;
      bre_pkg::ST_DRAIN: cmd          = '0;
      bre_pkg::ST_DIFF:  cmd.diff_ld  = 1'b1;
      bre_pkg::ST_MUL:   cmd.mul_ld   = 1'b1;
      bre_pkg::ST_DIV:   cmd.div_step = 1'b1;
      bre_pkg::ST_DONE:  cmd.out_ld   = out_free;
      default:           cmd          = '0;
    endcase
  end

  // state and counter registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bre_pkg::ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // result beat valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (cmd.out_ld) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/bre_dp.sv
// window store, maximum scan, contention arithmetic and result register
`timescale 1ns / 1ps
`default_nettype none

module bre_dp #(
  parameter int WINDOW_DEPTH = bre_pkg::WINDOW_DEPTH_DEF,
  localparam int AW = $clog2(2 * WINDOW_DEPTH),
  localparam int PW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1,
  localparam int DW = bre_pkg::DW
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire bre_pkg::cmd_t cmd,
  input  wire logic [AW-1:0] scan_addr,
  input  wire logic [DW-1:0] cw_min,
  input  wire logic [DW-1:0] cw_max,
  input  wire logic          est_en,
  input  wire logic          from_front,
  input  wire logic [DW-1:0] sender_distance,
  input  wire logic [DW-1:0] carried_max_distance,
  output logic      [DW-1:0] front_max_distance,
  output logic      [DW-1:0] back_max_distance,
  output logic      [DW-1:0] front_max_range,
  output logic      [DW-1:0] back_max_range,
  output logic      [DW-1:0] contention_window
);

  // captured message
  logic          side_r;
  logic [DW-1:0] dist_r;
  logic [DW-1:0] carried_r;

  // write pointers and entry valid bits
  logic [PW-1:0]             fptr_r, bptr_r;
  logic [2*WINDOW_DEPTH-1:0] valid_r;
  logic [AW-1:0]             wr_addr;
  logic                      wr_en;

  // scan pipeline
  logic [2*DW-1:0] rd_data;
  logic            rd_pend_r;
  logic            rd_vld_r;
  logic [AW-1:0]   rd_addr_r;
  logic [DW-1:0]   ent_dist, ent_range;
  logic            ent_front;
  logic [DW-1:0]   fd_max_r, bd_max_r, fr_max_r, br_max_r;

  // arithmetic
  logic [DW-1:0]   side_range, range_eff, diff, span;
  logic [DW-1:0]   range_r, diff_r, span_r;
  logic [2*DW-1:0] dvd_r;
  logic [DW-1:0]   rem_r;
  logic [DW:0]     trial;
  logic            q_bit;
  logic [2*DW:0]   sum;
  logic [DW-1:0]   cw_sat;

  // message capture
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      side_r    <= from_front;
      dist_r    <= sender_distance;
      carried_r <= carried_max_distance;
    end
  end

  // window write address: front entries sit above the back ones
  assign wr_en   = cmd.wr_win && est_en;
  assign wr_addr = side_r ? (AW'(WINDOW_DEPTH) + AW'(fptr_r)) : AW'(bptr_r);

  // pointer and valid bit upkeep
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fptr_r  <= '0;
      bptr_r  <= '0;
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[wr_addr] <= 1'b1;
      if (side_r) begin
        fptr_r <= (fptr_r == PW'(WINDOW_DEPTH - 1)) ? '0 : fptr_r + PW'(1);
      end else begin
        bptr_r <= (bptr_r == PW'(WINDOW_DEPTH - 1)) ? '0 : bptr_r + PW'(1);
      end
    end
  end

  // both sides' windows, entry = range in the upper half, distance in the lower
  bre_ram #(
    .WIDTH (2 * DW),
    .DEPTH (2 * WINDOW_DEPTH)
  ) u_win (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data ({carried_r, dist_r}),
    .rd_en   (cmd.scan_rd),
    .rd_addr (scan_addr),
    .rd_data (rd_data)
  );

  // read side bookkeeping, aligned with the ram output
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_pend_r <= 1'b0;
    end else begin
      rd_pend_r <= cmd.scan_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_rd) begin
      rd_addr_r <= scan_addr;
      rd_vld_r  <= valid_r[scan_addr];
    end
  end

  // unwritten entries read as their reset value
  assign ent_dist  = rd_vld_r ? rd_data[DW-1:0]    : '0;
  assign ent_range = rd_vld_r ? rd_data[2*DW-1:DW] : bre_pkg::DEFAULT_RANGE;
  assign ent_front = (rd_addr_r >= AW'(WINDOW_DEPTH));

  // running maxima
  always_ff @(posedge clk) begin
    if (cmd.scan_clr) begin
      fd_max_r <= '0;
      bd_max_r <= '0;
      fr_max_r <= '0;
      br_max_r <= '0;
    end else if (rd_pend_r) begin
      if (ent_front) begin
        if (ent_dist > fd_max_r) begin
          fd_max_r <= ent_dist;
        end
        if (ent_range > fr_max_r) begin
          fr_max_r <= ent_range;
        end
      end else begin
        if (ent_dist > bd_max_r) begin
          bd_max_r <= ent_dist;
        end
        if (ent_range > br_max_r) begin
          br_max_r <= ent_range;
        end
      end
    end
  end

  // distance gap and window span
  assign side_range = side_r ? fr_max_r : br_max_r;
  assign range_eff  = (side_range == '0) ? bre_pkg::DEFAULT_RANGE : side_range;
  assign diff       = (range_eff >= dist_r) ? (range_eff - dist_r) : (dist_r - range_eff);
  assign span       = (cw_max >= cw_min) ? (cw_max - cw_min) : '0;

  always_ff @(posedge clk) begin
    if (cmd.diff_ld) begin
      range_r <= range_eff;
      diff_r  <= diff;
      span_r  <= span;
    end
  end

  // restoring divider step: one quotient bit shifts into the dividend register
  assign trial = {rem_r, dvd_r[2*DW-1]};
  assign q_bit = (trial >= {1'b0, range_r});

  always_ff @(posedge clk) begin
    if (cmd.mul_ld) begin
      dvd_r <= (2*DW)'(diff_r) * (2*DW)'(span_r);
      rem_r <= '0;
    end else if (cmd.div_step) begin
      dvd_r <= {dvd_r[2*DW-2:0], q_bit};
      rem_r <= q_bit ? DW'(trial - {1'b0, range_r}) : trial[DW-1:0];
    end
  end

  // offset and saturate
  assign sum    = (2*DW+1)'(cw_min) + (2*DW+1)'(dvd_r);
  assign cw_sat = (sum > (2*DW+1)'({DW{1'b1}})) ? {DW{1'b1}} : sum[DW-1:0];

  // result register
  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      front_max_distance <= fd_max_r;
      back_max_distance  <= bd_max_r;
      front_max_range    <= fr_max_r;
      back_max_range     <= br_max_r;
      contention_window  <= cw_sat;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/broadcast_range_estimator.sv
// top level of the broadcast range estimator
//
// One input beat is one received broadcast message: in_tuser carries the side
// (front or back), in_tdata the sender distance and the sender's carried range.
// Each beat yields exactly one result beat with the four window maxima and a
// contention window in slots. Configuration is written through cfg_wr_en,
// cfg_addr and cfg_wdata; the user must write it only while no message is in
// flight, since the block itself does not enforce this. A message passes
// through the window scan, one ram entry per cycle over both sides, and the
// 32-step serial divider before its result is registered, and the block takes
// no new message until it is through with the last one.
// in_tready is high only while the block is idle; it does not wait for the
// result to be taken, since the result sits in its own output register. If the
// receiver stalls, the result holds and the next message stops at its final
// step until the register frees. Synchronous reset clears the state machine,
// the write pointers and all window entries (distances 0, ranges 100 m) and
// restores the configuration defaults.
`timescale 1ns / 1ps
`default_nettype none
`include "broadcast_range_estimator_assert.svh"

module broadcast_range_estimator #(
  parameter int WINDOW_DEPTH = bre_pkg::WINDOW_DEPTH_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // input stream
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // from_front
  input  wire logic [0:0]                       in_tuser,
  // sender_distance, carried_max_distance
  input  wire logic [bre_pkg::IN_DATA_W-1:0]    in_tdata,
  // result stream
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // front_max_distance, back_max_distance, front_max_range, back_max_range,
  // contention_window
  output logic      [bre_pkg::OUT_DATA_W-1:0]   out_tdata,
  // configuration write port
  input  wire logic                             cfg_wr_en,
  input  wire logic [bre_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  wire logic [bre_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int AW = $clog2(2 * WINDOW_DEPTH);
  localparam int DW = bre_pkg::DW;

  logic [DW-1:0] cw_min_r, cw_max_r;
  logic          est_en_r;
  bre_pkg::cmd_t cmd;
  logic [AW-1:0] scan_addr;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cw_min_r <= bre_pkg::CW_MIN_RST;
      cw_max_r <= bre_pkg::CW_MAX_RST;
      est_en_r <= 1'b1;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        bre_pkg::REG_CW_MIN: cw_min_r <= cfg_wdata[DW-1:0];
        bre_pkg::REG_CW_MAX: cw_max_r <= cfg_wdata[DW-1:0];
        bre_pkg::REG_EST_EN: est_en_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // sequencer
  bre_ctrl #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .cmd       (cmd),
    .scan_addr (scan_addr)
  );

  // datapath
  bre_dp #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .scan_addr            (scan_addr),
    .cw_min               (cw_min_r),
    .cw_max               (cw_max_r),
    .est_en               (est_en_r),
    .from_front           (in_tuser[0]),
    .sender_distance      (in_tdata[DW-1:0]),
    .carried_max_distance (in_tdata[2*DW-1:DW]),
    .front_max_distance   (out_tdata[DW-1:0]),
    .back_max_distance    (out_tdata[2*DW-1:DW]),
    .front_max_range      (out_tdata[3*DW-1:2*DW]),
    .back_max_range       (out_tdata[4*DW-1:3*DW]),
    .contention_window    (out_tdata[5*DW-1:4*DW])
  );

  // a message keeps the block busy for the following cycle
  `BRE_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_tvalid && in_tready, !in_tready,
                   "input accepted while previous message still in work")

  // a fresh result only comes out of a message in work
  `BRE_ASSERT_NOW(a_result_from_work, clk, rst_n, $rose(out_tvalid), !$past(in_tready),
                  "result beat raised while the block was idle")

endmodule

`default_nettype wire
